### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVA_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVA_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define SVA_NEXT_NORST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

### rtl/core/tfs_pkg.sv
// Package with types and constants of the triplet field smearing block.
`default_nettype none
package tfs_pkg;

  localparam int LINK_W          = 18;
  localparam int TRIP_W          = 32;
  localparam int SUM_W           = 48;
  localparam int CNT_W           = 4;
  localparam int P_W             = 36;
  localparam int VSUM_W          = 38;
  localparam int MAT_W           = 22;
  localparam int PROD_W          = MAT_W + TRIP_W;
  localparam int ACC_W           = 56;
  localparam int RND_W           = ACC_W - 16;
  localparam int SSUM_W          = 50;
  localparam int DIV_W           = 48;
  localparam int DEN_W           = 5;
  localparam int IN_DATA_W       = 168;
  localparam int OUT_DATA_W      = 96;
  localparam int DEFAULT_MAX_DIM = 4;
  localparam int NPROD           = 10;

  typedef enum logic [1:0] {
    CMD_CENTER = 2'd0,
    CMD_FWD    = 2'd1,
    CMD_BWD    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_FORM,
    B_DOT,
    B_DIV,
    B_OUT
  } bstate_t;

  typedef struct packed {
    cmd_t                     kind;
    logic                     last;
    logic signed [LINK_W-1:0] ua;
    logic signed [LINK_W-1:0] ub;
    logic signed [LINK_W-1:0] uc;
    logic signed [LINK_W-1:0] ud;
    logic signed [TRIP_W-1:0] tx;
    logic signed [TRIP_W-1:0] ty;
    logic signed [TRIP_W-1:0] tz;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  // Link component pairs multiplied in order: p00 p11 p22 p33 p12 p03 p13 p02 p01 p23.
  localparam logic [1:0] PROD_I [NPROD] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                            2'd0, 2'd1, 2'd0, 2'd0, 2'd2};
  localparam logic [1:0] PROD_J [NPROD] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                            2'd3, 2'd3, 2'd2, 2'd1, 2'd3};

endpackage
`default_nettype wire

### rtl/core/tfs_front.sv
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none
module tfs_front import tfs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // link_a, link_b, link_c, link_d, trip_x, trip_y, trip_z
  input  wire logic [1:0]           in_tuser,  // command
  input  wire logic                 in_tlast,
  input  wire logic                 pop,
  output q_out_t                    q
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item_in;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    item_in.kind = cmd_t'(in_tuser);
    item_in.last = in_tlast;
    item_in.ua   = in_tdata[17:0];
    item_in.ub   = in_tdata[35:18];
    item_in.uc   = in_tdata[53:36];
    item_in.ud   = in_tdata[71:54];
    item_in.tx   = in_tdata[103:72];
    item_in.ty   = in_tdata[135:104];
    item_in.tz   = in_tdata[167:136];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  assign q.vld  = (cnt_r != 2'd0);
  assign q.item = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

### rtl/core/tfs_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tfs_div import tfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CTR_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CTR_W-1:0] ctr_r, ctr_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ctr_nxt  = ctr_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt = {num_r[DIV_W-2:0], ge};
      ctr_nxt = ctr_r - CTR_W'(1);
      if (ctr_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      ctr_nxt  = CTR_W'(DIV_W - 1);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule
`default_nettype wire

### rtl/core/tfs_back.sv
// Back end: rotation, accumulation, final division and the output register.
`default_nettype none
module tfs_back import tfs_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire q_out_t                q,
  output logic                       pop,
  output div_req_t                   div_req,
  input  wire div_rsp_t              div_rsp,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser
);

  bstate_t                  state_r, state_nxt;
  item_t                    cur_r, cur_nxt;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [P_W-1:0]    p_r [NPROD];
  logic signed [P_W-1:0]    p_nxt [NPROD];
  logic signed [MAT_W-1:0]  m_r [9];
  logic signed [MAT_W-1:0]  m_nxt [9];
  logic signed [MAT_W-1:0]  m_calc [9];
  logic signed [VSUM_W-1:0] v [9];
  logic signed [VSUM_W-1:0] vr [9];
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [RND_W-1:0]  rnd_r, rnd_nxt;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic [3:0]               step_r, step_nxt;
  logic [1:0]               row_r, row_nxt;
  logic [1:0]               comp_r, comp_nxt;
  logic                     wait_r, wait_nxt;
  logic [TRIP_W-1:0]        res_r [3];
  logic [TRIP_W-1:0]        res_nxt [3];
  logic                     out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                     out_user_r, out_user_nxt;
  logic signed [MAT_W-1:0]  mul_a;
  logic signed [TRIP_W-1:0] mul_b;
  logic signed [LINK_W-1:0] u [4];
  logic signed [TRIP_W-1:0] t [3];
  logic signed [SSUM_W-1:0] ssum;
  logic                     cnt_full;
  logic [3:0]               pidx;
  logic [3:0]               row3, j3, eidx;
  logic [DEN_W-1:0]         den;
  logic [SUM_W-1:0]         sbits, mag;
  logic                     neg;
  logic [DIV_W-1:0]         neg_q;
  bstate_t                  after_item;

  assign u[0] = cur_r.ua;
  assign u[1] = cur_r.ub;
  assign u[2] = cur_r.uc;
  assign u[3] = cur_r.ud;
  assign t[0] = cur_r.tx;
  assign t[1] = cur_r.ty;
  assign t[2] = cur_r.tz;

  assign cnt_full = ({1'b0, cnt_r} >= (CNT_W + 1)'(2 * MAX_DIM));

  always_comb begin
    v[0] = VSUM_W'(p_r[0]) + VSUM_W'(p_r[1]) - VSUM_W'(p_r[2]) - VSUM_W'(p_r[3]);
    v[1] = (VSUM_W'(p_r[4]) + VSUM_W'(p_r[5])) <<< 1;
    v[2] = (VSUM_W'(p_r[6]) - VSUM_W'(p_r[7])) <<< 1;
    v[3] = (VSUM_W'(p_r[4]) - VSUM_W'(p_r[5])) <<< 1;
    v[4] = VSUM_W'(p_r[0]) - VSUM_W'(p_r[1]) + VSUM_W'(p_r[2]) - VSUM_W'(p_r[3]);
    v[5] = (VSUM_W'(p_r[8]) + VSUM_W'(p_r[9])) <<< 1;
    v[6] = (VSUM_W'(p_r[7]) + VSUM_W'(p_r[6])) <<< 1;
    v[7] = (VSUM_W'(p_r[9]) - VSUM_W'(p_r[8])) <<< 1;
    v[8] = VSUM_W'(p_r[0]) - VSUM_W'(p_r[1]) - VSUM_W'(p_r[2]) + VSUM_W'(p_r[3]);
    for (int k = 0; k < 9; k++) begin
      vr[k]     = v[k] + VSUM_W'(32768);
      m_calc[k] = vr[k][VSUM_W-1:16];
    end
  end

  assign acc_rnd = acc_r + ACC_W'(32768);
  assign ssum    = SSUM_W'(sum_r[row_r]) + SSUM_W'(rnd_r);
  assign row3    = {1'b0, row_r, 1'b0} + {2'b00, row_r};
  assign j3      = {1'b0, step_r[1:0], 1'b0} + {2'b00, step_r[1:0]};
  assign eidx    = (cur_r.kind == CMD_FWD) ? (row3 + {2'b00, step_r[1:0]}) :
                                             (j3 + {2'b00, row_r});
  assign pidx    = step_r - 4'd1;
  assign den     = {1'b0, cnt_r} + DEN_W'(1);
  assign sbits   = sum_r[comp_r];
  assign neg     = sbits[SUM_W-1];
  assign mag     = neg ? (~sbits + SUM_W'(1)) : sbits;
  assign neg_q   = DIV_W'(0) - div_rsp.quo;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    sat_nxt      = sat_r;
    p_nxt        = p_r;
    m_nxt        = m_r;
    acc_nxt      = acc_r;
    rnd_nxt      = rnd_r;
    step_nxt     = step_r;
    row_nxt      = row_r;
    comp_nxt     = comp_r;
    wait_nxt     = wait_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    pop          = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    after_item   = cur_r.last ? B_DIV : B_IDLE;

    unique case (state_r)
      B_IDLE: begin
        comp_nxt = '0;
        wait_nxt = 1'b0;
        if (q.vld) begin
          pop        = 1'b1;
          cur_nxt    = q.item;
          after_item = q.item.last ? B_DIV : B_IDLE;
          state_nxt  = after_item;
          unique case (q.item.kind)
            CMD_CENTER: begin
              sum_nxt[0] = SUM_W'(q.item.tx);
              sum_nxt[1] = SUM_W'(q.item.ty);
              sum_nxt[2] = SUM_W'(q.item.tz);
              cnt_nxt    = '0;
              sat_nxt    = 1'b0;
            end
            CMD_FWD, CMD_BWD: begin
              if (cnt_full) begin
                sat_nxt = 1'b1;
              end else begin
                step_nxt  = '0;
                state_nxt = B_PROD;
              end
            end
            CMD_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      B_PROD: begin
        if (step_r < 4'(NPROD)) begin
          mul_a = MAT_W'(u[PROD_I[step_r]]);
          mul_b = TRIP_W'(u[PROD_J[step_r]]);
        end
        if (step_r != 4'd0) begin
          p_nxt[pidx] = P_W'(prod_r);
        end
        if (step_r == 4'(NPROD)) begin
          state_nxt = B_FORM;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      B_FORM: begin
        m_nxt     = m_calc;
        row_nxt   = '0;
        step_nxt  = '0;
        state_nxt = B_DOT;
      end
      B_DOT: begin
        comp_nxt = '0;
        wait_nxt = 1'b0;
        if (step_r < 4'd3) begin
          mul_a = m_r[eidx];
          mul_b = t[step_r[1:0]];
        end
        step_nxt = step_r + 4'd1;
        priority case (step_r)
          4'd1: acc_nxt = ACC_W'(prod_r);
          4'd2, 4'd3: acc_nxt = acc_r + ACC_W'(prod_r);
          4'd4: rnd_nxt = acc_rnd[ACC_W-1:16];
          4'd5: begin
            if (ssum[SSUM_W-1:SUM_W-1] != '0 && ssum[SSUM_W-1:SUM_W-1] != '1) begin
              sat_nxt        = 1'b1;
              sum_nxt[row_r] = ssum[SSUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} :
                                                {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
              sum_nxt[row_r] = ssum[SUM_W-1:0];
            end
            step_nxt = '0;
            if (row_r == 2'd2) begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = after_item;
            end else begin
              row_nxt = row_r + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
      B_DIV: begin
        if (!wait_r) begin
          div_req.start = 1'b1;
          div_req.num   = mag + DIV_W'(den >> 1);
          div_req.den   = den;
          wait_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          wait_nxt = 1'b0;
          if (!neg) begin
            if (div_rsp.quo > DIV_W'(32'h7fff_ffff)) begin
              res_nxt[comp_r] = 32'h7fff_ffff;
              sat_nxt         = 1'b1;
            end else begin
              res_nxt[comp_r] = div_rsp.quo[TRIP_W-1:0];
            end
          end else begin
            if (div_rsp.quo > DIV_W'(32'h8000_0000)) begin
              res_nxt[comp_r] = 32'h8000_0000;
              sat_nxt         = 1'b1;
            end else begin
              res_nxt[comp_r] = neg_q[TRIP_W-1:0];
            end
          end
          if (comp_r == 2'd2) begin
            state_nxt = B_OUT;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      B_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {res_r[2], res_r[1], res_r[0]};
          out_user_nxt = sat_r;
          sum_nxt[0]   = '0;
          sum_nxt[1]   = '0;
          sum_nxt[2]   = '0;
          cnt_nxt      = '0;
          sat_nxt      = 1'b0;
          state_nxt    = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
      sum_r[2]  <= '0;
      cnt_r     <= '0;
      sat_r     <= 1'b0;
      wait_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      sat_r     <= sat_nxt;
      wait_r    <= wait_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    rnd_r      <= rnd_nxt;
    step_r     <= step_nxt;
    row_r      <= row_nxt;
    comp_r     <= comp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

### rtl/core/triplet_field_smearing.sv
// Top level of the triplet field smearing block.
//
// Input stream: one transaction per item. tuser carries the command (center,
// forward or backward neighbor, or none), tdata the four link components and the
// neighbor triplet, and tlast ends the run of one site.
// Output stream: one transaction per run, sent after the tlast item, with the
// smeared triplet in tdata and the saturation flag in tuser.
// A two-entry queue sits between the front end and the sequencer, so input is
// taken while the sequencer works and while a result waits in the output
// register.
// In the sequencer a center item is taken in the idle state, a neighbor item
// passes ten link products and nine dot-product terms through one shared
// multiplier, and the final division runs the bit-serial divider once for each
// of the three components in turn.
// Reset clears the queue, the running sum, the neighbor count and the flag,
// and drops out_tvalid. A stalled receiver keeps the result in the output
// register; the sequencer waits to hand over the next result until it is
// taken, and the queue fills and lowers in_tready.
`default_nettype none
module triplet_field_smearing import tfs_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // link_a, link_b, link_c, link_d, trip_x, trip_y, trip_z
  input  wire logic [1:0]            in_tuser,   // command
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // smeared_x, smeared_y, smeared_z
  output logic                       out_tuser   // saturated
);

  q_out_t   q;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .q         (q)
  );

  tfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tfs_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q          (q),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### rtl/core/tfs_checker.sv
// Port-level assertions for the triplet field smearing block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module tfs_sva import tfs_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // A stalled result transaction holds its payload.
  `SVA_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // The queue only fills through an accepted input transaction.
  `SVA_IMPLY(a_ready_fall, clk, rst_n, $fell(in_tready), $past(in_tvalid && in_tready))
  // After reset the queue is empty and no result is pending.
  `SVA_NEXT_NORST(a_rst_ready, clk, !rst_n, in_tready)
  `SVA_NEXT_NORST(a_rst_out, clk, !rst_n, !out_tvalid)

endmodule

bind triplet_field_smearing tfs_sva u_tfs_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
